/* rtl/core/jfr_pkg.sv */
// Shared types, codes and constants of the job queue with removal by id.
`default_nettype none

package jfr_pkg;

   localparam int ID_W             = 16;
   localparam int PAYLOAD_W        = 32;
   localparam int LEVEL_W          = 5;
   localparam int PAYLOAD_BITS_MAX = 64;
   localparam int QUEUE_DEPTH_DEF  = 16;
   localparam int PAYLOAD_BITS_DEF = 32;

   typedef enum logic [1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_DEQUEUE = 2'd1,
      ACT_REMOVE  = 2'd2,
      ACT_CLEAR   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_LOAD,
      S_HOLD
   } state_type;

   typedef struct packed {
      status_type             status;
      logic                   front_valid;
      logic [ID_W-1:0]        front_id;
      logic [PAYLOAD_W-1:0]   front_payload;
      logic [PAYLOAD_W-1:0]   taken_payload;
      logic [LEVEL_W-1:0]     queue_level;
   } result_type;

endpackage

`default_nettype wire

/* rtl/core/jfr_ram.sv */
// Generic single-write, single-read memory with a registered read port.
`default_nettype none

module jfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/jfr_ctrl.sv */
// Command sequencer: ring pointers, front cache, search and compaction over the slot memory.
`default_nettype none

module jfr_ctrl #(
   parameter int QUEUE_DEPTH  = jfr_pkg::QUEUE_DEPTH_DEF,
   parameter int PAYLOAD_BITS = jfr_pkg::PAYLOAD_BITS_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_ready,
   input  wire logic [1:0]                                req_action,
   input  wire logic [jfr_pkg::ID_W-1:0]                  req_job_id,
   input  wire logic [jfr_pkg::PAYLOAD_W-1:0]             req_job_payload,
   output logic                                           ram_wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0]                 ram_wr_addr,
   output logic [jfr_pkg::ID_W+PAYLOAD_BITS-1:0]          ram_wr_data,
   output logic                                           ram_rd_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0]                 ram_rd_addr,
   input  wire logic [jfr_pkg::ID_W+PAYLOAD_BITS-1:0]     ram_rd_data,
   output logic                                           res_valid,
   input  wire logic                                      res_ready,
   output jfr_pkg::result_type                            res
);

   import jfr_pkg::*;

   localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = ID_W + PAYLOAD_BITS;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] offs);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= (ADDR_W + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (ADDR_W + 1)'(QUEUE_DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   state_type               state_ff, state_in;
   logic [ADDR_W-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [ID_W-1:0]         front_id_ff, front_id_in;
   logic [PAYLOAD_BITS-1:0] front_pay_ff, front_pay_in;
   logic [ID_W-1:0]         key_ff, key_in;
   logic [ADDR_W-1:0]       pos_ff, pos_in;
   status_type              res_status_ff, res_status_in;
   logic [PAYLOAD_BITS-1:0] res_taken_ff, res_taken_in;

   action_type                  action;
   logic [PAYLOAD_BITS_MAX-1:0] in_wide;
   logic [PAYLOAD_BITS-1:0]     in_pay;
   logic [ID_W-1:0]             rd_id;
   logic [PAYLOAD_BITS-1:0]     rd_pay;
   logic                        is_empty;
   logic                        is_full;
   logic                        single;
   logic                        pos_last;
   logic [ADDR_W-1:0]           pos_next;
   logic [ADDR_W-1:0]           head_inc;
   logic                        front_hit;
   logic                        rd_hit;
   logic [PAYLOAD_BITS_MAX-1:0] front_wide;
   logic [PAYLOAD_BITS_MAX-1:0] taken_wide;
   logic [CNT_W+LEVEL_W-1:0]    level_wide;

   assign action    = action_type'(req_action);
   assign in_wide   = PAYLOAD_BITS_MAX'(req_job_payload);
   assign in_pay    = in_wide[PAYLOAD_BITS-1:0];
   assign rd_id     = ram_rd_data[ENTRY_W-1 -: ID_W];
   assign rd_pay    = ram_rd_data[PAYLOAD_BITS-1:0];
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == FULL_COUNT);
   assign single    = (count_ff == CNT_W'(1));
   assign pos_last  = ((CNT_W'(pos_ff) + CNT_W'(1)) == count_ff);
   assign pos_next  = pos_ff + ADDR_W'(1);
   assign head_inc  = slot_addr(head_ff, ADDR_W'(1));
   assign front_hit = (front_id_ff == req_job_id);
   assign rd_hit    = (rd_id == key_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (action)
                  ACT_DEQUEUE: begin
                     state_in = (!is_empty && !single) ? S_LOAD : S_HOLD;
                  end
                  ACT_REMOVE: begin
                     if (is_empty) begin
                        state_in = S_HOLD;
                     end else if (front_hit) begin
                        state_in = single ? S_HOLD : S_LOAD;
                     end else if (single) begin
                        state_in = S_HOLD;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_HOLD;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (rd_hit) begin
               state_in = pos_last ? S_HOLD : S_SHIFT;
            end else if (pos_last) begin
               state_in = S_HOLD;
            end
         end
         S_SHIFT: begin
            if (pos_last) begin
               state_in = S_HOLD;
            end
         end
         S_LOAD: begin
            state_in = S_HOLD;
         end
         S_HOLD: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      front_id_in   = front_id_ff;
      front_pay_in  = front_pay_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      res_status_in = res_status_ff;
      res_taken_in  = res_taken_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = slot_addr(head_ff, pos_ff - ADDR_W'(1));
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = slot_addr(head_ff, pos_next);
      req_ready     = (state_ff == S_IDLE);
      res_valid     = (state_ff == S_HOLD);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_status_in = ST_DONE;
               res_taken_in  = '0;
               case (action)
                  ACT_ENQUEUE: begin
                     if (is_full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = slot_addr(head_ff, count_ff[ADDR_W-1:0]);
                        ram_wr_data = {req_job_id, in_pay};
                        count_in    = count_ff + CNT_W'(1);
                        if (is_empty) begin
                           front_id_in  = req_job_id;
                           front_pay_in = in_pay;
                        end
                     end
                  end
                  ACT_DEQUEUE, ACT_REMOVE: begin
                     if (is_empty) begin
                        res_status_in = ST_EMPTY;
                     end else if (action == ACT_DEQUEUE || front_hit) begin
                        res_taken_in = front_pay_ff;
                        head_in      = head_inc;
                        count_in     = count_ff - CNT_W'(1);
                        ram_rd_en    = !single;
                        ram_rd_addr  = head_inc;
                     end else if (single) begin
                        res_status_in = ST_NOT_FOUND;
                     end else begin
                        key_in      = req_job_id;
                        pos_in      = ADDR_W'(1);
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = head_inc;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (!pos_last) begin
               ram_rd_en = 1'b1;
               pos_in    = pos_next;
            end
            if (rd_hit) begin
               res_taken_in = rd_pay;
               if (pos_last) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end else if (pos_last) begin
               res_status_in = ST_NOT_FOUND;
            end
         end
         S_SHIFT: begin
            ram_wr_en = 1'b1;
            if (!pos_last) begin
               ram_rd_en = 1'b1;
               pos_in    = pos_next;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         S_LOAD: begin
            front_id_in  = rd_id;
            front_pay_in = rd_pay;
         end
         default: begin
            pos_in = pos_ff;
         end
      endcase
   end

   always_comb begin
      front_wide                   = '0;
      front_wide[PAYLOAD_BITS-1:0] = front_pay_ff;
      taken_wide                   = '0;
      taken_wide[PAYLOAD_BITS-1:0] = res_taken_ff;
      level_wide                   = (CNT_W + LEVEL_W)'(count_ff);
      res.status                   = res_status_ff;
      res.front_valid              = !is_empty;
      res.front_id                 = is_empty ? '0 : front_id_ff;
      res.front_payload            = is_empty ? '0 : front_wide[PAYLOAD_W-1:0];
      res.taken_payload            = taken_wide[PAYLOAD_W-1:0];
      res.queue_level              = level_wide[LEVEL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      front_id_ff   <= front_id_in;
      front_pay_ff  <= front_pay_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_taken_ff  <= res_taken_in;
   end

endmodule

`default_nettype wire

/* rtl/core/jfr_rsp.sv */
// Result register stage between the sequencer and the result channel.
`default_nettype none

module jfr_rsp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          res_valid,
   output logic                               res_ready,
   input  wire jfr_pkg::result_type           res,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_front_valid,
   output logic [jfr_pkg::ID_W-1:0]           rsp_front_id,
   output logic [jfr_pkg::PAYLOAD_W-1:0]      rsp_front_payload,
   output logic [jfr_pkg::PAYLOAD_W-1:0]      rsp_taken_payload,
   output logic [jfr_pkg::LEVEL_W-1:0]        rsp_queue_level
);

   import jfr_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;
   logic       load;

   assign res_ready = !rsp_valid_ff || rsp_ready;
   assign load      = res_valid && res_ready;

   always_comb begin
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = load ? res : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_data_ff.status;
   assign rsp_front_valid   = rsp_data_ff.front_valid;
   assign rsp_front_id      = rsp_data_ff.front_id;
   assign rsp_front_payload = rsp_data_ff.front_payload;
   assign rsp_taken_payload = rsp_data_ff.taken_payload;
   assign rsp_queue_level   = rsp_data_ff.queue_level;

endmodule

`default_nettype wire

/* rtl/core/job_fifo_with_remove_by_id.sv */
// Top level of the job queue with removal by id.
//
// Commands arrive on the req_ channel (valid/ready) and each gives exactly one item on
// the rsp_ channel (valid/ready): enqueue, dequeue front, remove first matching id, or
// clear. Entries live in one slot memory used as a ring; the front entry is also held
// in registers, so a front match needs no search.
// Enqueue, clear and refused commands go straight to the result; dequeue and removal
// at the front first reload the front registers from memory, unless they leave the
// queue empty. Other removals read the memory from the second entry on for the first
// matching id, then move each entry behind the match up one slot. The search and
// the compaction each read one memory entry per cycle through the single read port.
// One command is worked on at a time: a new one is taken only after the last has
// passed its result to the output register; req_ready is high whenever the sequencer
// is idle, also while an earlier result waits in the output register.
// Reset empties the queue; the memory needs no clearing pass.
// A stalled receiver holds the result in the output register; a finished command then
// waits until that register frees before the next command is taken.
`default_nettype none

module job_fifo_with_remove_by_id #(
   parameter int QUEUE_DEPTH  = jfr_pkg::QUEUE_DEPTH_DEF,
   parameter int PAYLOAD_BITS = jfr_pkg::PAYLOAD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_action,
   input  wire logic [jfr_pkg::ID_W-1:0]      req_job_id,
   input  wire logic [jfr_pkg::PAYLOAD_W-1:0] req_job_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_front_valid,
   output logic [jfr_pkg::ID_W-1:0]           rsp_front_id,
   output logic [jfr_pkg::PAYLOAD_W-1:0]      rsp_front_payload,
   output logic [jfr_pkg::PAYLOAD_W-1:0]      rsp_taken_payload,
   output logic [jfr_pkg::LEVEL_W-1:0]        rsp_queue_level
);

   import jfr_pkg::*;

   localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
   localparam int ENTRY_W = ID_W + PAYLOAD_BITS;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic               res_valid;
   logic               res_ready;
   result_type         res;

   jfr_ctrl #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_job_id      (req_job_id),
      .req_job_payload (req_job_payload),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .res_valid       (res_valid),
      .res_ready       (res_ready),
      .res             (res)
   );

   jfr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   jfr_rsp u_rsp (
      .clock             (clock),
      .reset             (reset),
      .res_valid         (res_valid),
      .res_ready         (res_ready),
      .res               (res),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_front_valid   (rsp_front_valid),
      .rsp_front_id      (rsp_front_id),
      .rsp_front_payload (rsp_front_payload),
      .rsp_taken_payload (rsp_taken_payload),
      .rsp_queue_level   (rsp_queue_level)
   );

endmodule

`default_nettype wire

/* rtl/core/jfr_checker.sv */
// Port-level checks of the job queue and their binding to the top level.
`default_nettype none

module jfr_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [1:0]                    rsp_status,
   input wire logic                          rsp_front_valid,
   input wire logic [jfr_pkg::ID_W-1:0]      rsp_front_id,
   input wire logic [jfr_pkg::PAYLOAD_W-1:0] rsp_front_payload,
   input wire logic [jfr_pkg::PAYLOAD_W-1:0] rsp_taken_payload,
   input wire logic [jfr_pkg::LEVEL_W-1:0]   rsp_queue_level
);

   import jfr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_taken_payload) && $stable(rsp_queue_level))
      else $error("A stalled result item changed.");

   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_front_valid |-> rsp_queue_level == '0
         && rsp_front_id == '0 && rsp_front_payload == '0)
      else $error("An empty queue reported a front entry.");

   a_failed_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_taken_payload == '0)
      else $error("A refused command reported a taken payload.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("A command was taken while the previous one was still in work.");

endmodule

bind job_fifo_with_remove_by_id jfr_checker u_jfr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_front_valid   (rsp_front_valid),
   .rsp_front_id      (rsp_front_id),
   .rsp_front_payload (rsp_front_payload),
   .rsp_taken_payload (rsp_taken_payload),
   .rsp_queue_level   (rsp_queue_level)
);

`default_nettype wire

/* tb/job_fifo_with_remove_by_id_tb.sv */
// Self-checking testbench for the job queue with removal by id.
`timescale 1ns / 1ps

module job_fifo_with_remove_by_id_tb;
   import jfr_pkg::*;

   localparam int QUEUE_DEPTH   = QUEUE_DEPTH_DEF;
   localparam int RANDOM_ITEMS  = 540;
   localparam int STALL_LIMIT   = 5000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int REPORT_LIMIT  = 50;

   typedef struct packed {
      logic [ID_W-1:0]      id;
      logic [PAYLOAD_W-1:0] payload;
   } job_entry_type;

   class job_queue_shadow;
      job_entry_type queued_jobs[$];
      result_type    pending_responses[$];
      int            error_count = 0;
      int            responses_checked = 0;
      int            action_count[4] = '{0, 0, 0, 0};
      int            status_count[4] = '{0, 0, 0, 0};
      int            full_reached = 0;

      function void note_command(action_type act, logic [ID_W-1:0] id,
                                 logic [PAYLOAD_W-1:0] payload);
         result_type    want;
         int            hit;
         job_entry_type job;
         want = '0;
         want.status = ST_DONE;
         hit = -1;
         case (act)
            ACT_ENQUEUE: begin
               if (queued_jobs.size() >= QUEUE_DEPTH) begin
                  want.status = ST_FULL;
               end else begin
                  job.id = id;
                  job.payload = payload;
                  queued_jobs.push_back(job);
                  if (queued_jobs.size() == QUEUE_DEPTH) full_reached++;
               end
            end
            ACT_DEQUEUE: begin
               if (queued_jobs.size() == 0) begin
                  want.status = ST_EMPTY;
               end else begin
                  want.taken_payload = queued_jobs[0].payload;
                  void'(queued_jobs.pop_front());
               end
            end
            ACT_REMOVE: begin
               if (queued_jobs.size() == 0) begin
                  want.status = ST_EMPTY;
               end else begin
                  foreach (queued_jobs[i])
                     if (hit < 0 && queued_jobs[i].id == id) hit = i;
                  if (hit < 0) begin
                     want.status = ST_NOT_FOUND;
                  end else begin
                     want.taken_payload = queued_jobs[hit].payload;
                     queued_jobs.delete(hit);
                  end
               end
            end
            default: begin
               queued_jobs.delete();
            end
         endcase
         if (queued_jobs.size() > 0) begin
            want.front_valid = 1'b1;
            want.front_id = queued_jobs[0].id;
            want.front_payload = queued_jobs[0].payload;
         end
         want.queue_level = LEVEL_W'(queued_jobs.size());
         action_count[act]++;
         status_count[want.status]++;
         pending_responses.push_back(want);
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] have);
         if (want !== have) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, have);
         end
      endfunction

      function void check_response(result_type have);
         result_type want;
         if (pending_responses.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: item on rsp_ with none expected, got %0h", $time, have);
         end else begin
            want = pending_responses.pop_front();
            responses_checked++;
            compare_field("status", 64'(want.status), 64'(have.status));
            compare_field("front_valid", 64'(want.front_valid), 64'(have.front_valid));
            compare_field("front_id", 64'(want.front_id), 64'(have.front_id));
            compare_field("front_payload", 64'(want.front_payload), 64'(have.front_payload));
            compare_field("taken_payload", 64'(want.taken_payload), 64'(have.taken_payload));
            compare_field("queue_level", 64'(want.queue_level), 64'(have.queue_level));
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_action = '0;
   logic [ID_W-1:0]      req_job_id = '0;
   logic [PAYLOAD_W-1:0] req_job_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_status;
   logic                 rsp_front_valid;
   logic [ID_W-1:0]      rsp_front_id;
   logic [PAYLOAD_W-1:0] rsp_front_payload;
   logic [PAYLOAD_W-1:0] rsp_taken_payload;
   logic [LEVEL_W-1:0]   rsp_queue_level;

   int              sender_idle_pct = 31;
   int              receiver_idle_pct = 60;
   bit              filling = 1'b1;
   job_queue_shadow shadow = new;

   job_fifo_with_remove_by_id DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_job_id        (req_job_id),
      .req_job_payload   (req_job_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_front_valid   (rsp_front_valid),
      .rsp_front_id      (rsp_front_id),
      .rsp_front_payload (rsp_front_payload),
      .rsp_taken_payload (rsp_taken_payload),
      .rsp_queue_level   (rsp_queue_level)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin : response_monitor
      result_type have;
      if (!reset && rsp_valid && rsp_ready) begin
         have.status = status_type'(rsp_status);
         have.front_valid = rsp_front_valid;
         have.front_id = rsp_front_id;
         have.front_payload = rsp_front_payload;
         have.taken_payload = rsp_taken_payload;
         have.queue_level = rsp_queue_level;
         shadow.check_response(have);
      end
      rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   initial begin : watchdog
      int stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("job_fifo_with_remove_by_id regression: fail");
      $finish;
   end

   // Called at a rising edge; returns at the edge at which the item is accepted.
   task automatic send_command(action_type act, logic [ID_W-1:0] id,
                               logic [PAYLOAD_W-1:0] payload);
      int gap;
      gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_job_id <= id;
      req_job_payload <= payload;
      do @(posedge clock); while (!req_ready);
      shadow.note_command(act, id, payload);
   endtask

   task automatic send_random_commands(int count);
      action_type           act;
      logic [ID_W-1:0]      id;
      logic [PAYLOAD_W-1:0] payload;
      int                   level;
      int                   pick;
      for (int n = 0; n < count; n++) begin
         level = shadow.queued_jobs.size();
         if (level == QUEUE_DEPTH) filling = 1'b0;
         else if (level == 0) filling = 1'b1;
         else if ($urandom_range(0, 99) < 3) filling = !filling;
         pick = $urandom_range(0, 99);
         if (filling)
            act = pick < 60 ? ACT_ENQUEUE : pick < 72 ? ACT_DEQUEUE :
                  pick < 98 ? ACT_REMOVE : ACT_CLEAR;
         else
            act = pick < 20 ? ACT_ENQUEUE : pick < 50 ? ACT_DEQUEUE :
                  pick < 97 ? ACT_REMOVE : ACT_CLEAR;
         pick = $urandom_range(0, 99);
         if (act == ACT_REMOVE && level > 0 && pick < 55)
            id = shadow.queued_jobs[$urandom_range(0, level - 1)].id;
         else if (pick < 85)
            id = ID_W'($urandom_range(0, 11));
         else
            id = ID_W'($urandom);
         pick = $urandom_range(0, 99);
         payload = pick < 4 ? '0 : pick < 8 ? '1 : PAYLOAD_W'($urandom);
         send_command(act, id, payload);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_command(ACT_DEQUEUE, 16'h0001, 32'h0);
      send_command(ACT_REMOVE, 16'h0001, 32'h0);
      send_command(ACT_CLEAR, 16'h0000, 32'h0);
      send_command(ACT_ENQUEUE, 16'h0000, 32'h0000_0000);
      send_command(ACT_ENQUEUE, 16'hFFFF, 32'hFFFF_FFFF);
      send_command(ACT_ENQUEUE, 16'h0005, 32'hA5A5_A5A5);
      send_command(ACT_ENQUEUE, 16'h0005, 32'h5A5A_5A5A);
      send_command(ACT_REMOVE, 16'h1234, 32'h0);
      send_command(ACT_REMOVE, 16'h0005, 32'h0);
      send_command(ACT_DEQUEUE, 16'h0000, 32'h0);
      send_command(ACT_REMOVE, 16'hFFFF, 32'h0);
      for (int k = 0; k < QUEUE_DEPTH - 1; k++)
         send_command(ACT_ENQUEUE, ID_W'(16'h0100 + k), PAYLOAD_W'($urandom));
      send_command(ACT_ENQUEUE, 16'h7777, 32'h1234_5678);
      send_command(ACT_REMOVE, ID_W'(16'h0100 + QUEUE_DEPTH - 2), 32'h0);
      send_command(ACT_CLEAR, 16'h0000, 32'h0);

      send_random_commands(RANDOM_ITEMS);
      sender_idle_pct = 60;
      receiver_idle_pct = 31;
      send_random_commands(RANDOM_ITEMS);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      send_random_commands(RANDOM_ITEMS);
      req_valid <= 1'b0;

      while (shadow.pending_responses.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d commands: %0d enqueue, %0d dequeue, %0d remove, %0d clear; %0d results.",
               shadow.action_count.sum(), shadow.action_count[ACT_ENQUEUE],
               shadow.action_count[ACT_DEQUEUE], shadow.action_count[ACT_REMOVE],
               shadow.action_count[ACT_CLEAR], shadow.responses_checked);
      $display("Outcomes: %0d done, %0d empty, %0d not found, %0d full; queue filled %0d times.",
               shadow.status_count[ST_DONE], shadow.status_count[ST_EMPTY],
               shadow.status_count[ST_NOT_FOUND], shadow.status_count[ST_FULL],
               shadow.full_reached);
      if (shadow.error_count == 0)
         $display("job_fifo_with_remove_by_id regression: pass");
      else
         $display("job_fifo_with_remove_by_id regression: fail");
      $finish;
   end

endmodule

/* job_fifo_with_remove_by_id.f */
rtl/core/jfr_pkg.sv
rtl/core/jfr_ram.sv
rtl/core/jfr_ctrl.sv
rtl/core/jfr_rsp.sv
rtl/core/job_fifo_with_remove_by_id.sv
rtl/core/jfr_checker.sv
tb/job_fifo_with_remove_by_id_tb.sv
